[rtl/core/irsc_pkg.sv]
package irsc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SAMPLE_PERIOD = 3'd0;
    localparam logic [2:0] CFG_MIN_DISTANCE  = 3'd1;
    localparam logic [2:0] CFG_MAX_DISTANCE  = 3'd2;
    localparam logic [2:0] CFG_MAX_JUMP      = 3'd3;
    localparam logic [2:0] CFG_EMA_ALPHA     = 3'd4;
    localparam logic [2:0] CFG_FRESH_LIMIT   = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_SAMPLE_PERIOD = 16'd40;
    localparam logic [15:0] RST_MIN_DISTANCE  = 16'd2560;
    localparam logic [15:0] RST_MAX_DISTANCE  = 16'd20480;
    localparam logic [15:0] RST_MAX_JUMP      = 16'd6400;
    localparam logic [15:0] RST_EMA_ALPHA     = 16'd19661;
    localparam logic [15:0] RST_FRESH_LIMIT   = 16'd100;

    localparam logic [15:0] DIST_MAX = 16'hFFFF;
    localparam logic [31:0] AGE_NONE = 32'hFFFF_FFFF;

    // Conditioned word after the state-update stage.
    typedef struct packed {
        logic        accepted;
        logic        in_range;
        logic        sample_present;
        logic        timeout;
        logic [15:0] distance;
        logic [31:0] age_ms;
        logic [15:0] streak;
        logic [15:0] timeouts;
    } irsc_cond_t;

    // Result word; the first field sits in the highest bits.
    typedef struct packed {
        logic [2:0]  pad;
        logic [15:0] timeouts;
        logic [15:0] streak;
        logic        fresh;
        logic [31:0] age_ms;
        logic [15:0] filtered;
        logic [15:0] distance;
        logic        timeout;
        logic        sample_present;
        logic        in_range;
        logic        accepted;
    } irsc_result_t;

    // Integer square root, one result bit per step.
    function automatic logic [63:0] irsc_isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = val;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Base-two logarithm in Q16, fraction bits found by repeated squaring.
    function automatic logic [63:0] irsc_log2_q16(input logic [31:0] x);
        logic [63:0] m;
        logic [63:0] frac;
        int unsigned n;
        n = 0;
        for (int i = 1; i < 32; i++) begin
            if ((x >> i) != 32'd0) n = i;
        end
        m = ({32'd0, x} << 16) >> n;
        frac = 64'd0;
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 16;
            frac = frac << 1;
            if (m >= 64'h2_0000) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(n) << 16) | frac;
    endfunction

    // Power-law conversion of one converter code to a distance in cm.
    // Evaluated only at elaboration to fill the conversion table.
    function automatic logic [15:0] irsc_adc_to_dist(input int unsigned adc,
                                                     input int unsigned adc_bits,
                                                     input int unsigned frac_bits);
        logic [63:0] u;
        logic [63:0] e;
        logic [63:0] p;
        logic [63:0] root;
        logic [63:0] prod;
        logic [63:0] lg5;
        logic [63:0] lga;
        logic [15:0] f;
        int          ip;
        int          s;
        if (adc < 10 || 64'(adc) * 64'd100 < (64'd1 << adc_bits)) return 16'd0;
        lg5 = irsc_log2_q16(32'd5);
        lga = irsc_log2_q16(32'(adc));
        u = 64'd76874 * ((64'(adc_bits) << 16) - lg5) + (64'd8 << 32);
        u = u - 64'd76874 * lga;
        e = u >> 16;
        ip = int'(e >> 16);
        f = e[15:0];
        p = 64'd1 << 30;
        root = 64'd2 << 30;
        for (int k = 0; k < 16; k++) begin
            root = irsc_isqrt64(root << 30);
            if (f[15-k]) p = (p * root) >> 30;
        end
        s = 54 - ip - int'(frac_bits);
        if (s < 1) return DIST_MAX;
        if (s > 62) return 16'd0;
        prod = (64'd1965294 * p + (64'd1 << (s - 1))) >> s;
        return (prod > 64'(DIST_MAX)) ? DIST_MAX : prod[15:0];
    endfunction

endpackage

[rtl/core/ir_range_sample_conditioner_unit.sv]
// Range sensor sample conditioner. Each input word carries a millisecond time and a raw
// converter code; every input word yields exactly one result word. A read is taken once
// at least sample_period_ms have passed since the last taken read; its code is converted
// to a Q8.8 cm distance by a fixed power-law table, range checked, limited to max_jump
// around the last distance and fed into an exponential average seeded by the first good
// value. The block takes one word per cycle unless m_tready back-pressure stalls it; each
// result passes the conversion table read, the state-update stage and the averaging stage
// (one 17x25 multiply), each holding one register. Configuration is written through cfg_we,
// cfg_addr and cfg_wdata; the user must do so only while the block is idle, as the block
// does not enforce it. The table is constant and needs no fill time after reset.
module ir_range_sample_conditioner_unit
    import irsc_pkg::*;
#(
    parameter int unsigned ADC_BITS       = 10,
    parameter int unsigned DIST_FRAC_BITS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input word: now_ms, adc_sample, zero fill.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((32+ADC_BITS+7)/8)*8-1:0]   s_tdata,
    // Result word: accepted, in_range, sample_present, timeout, distance, filtered,
    // age_ms, fresh, streak, timeouts, zero fill.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [$bits(irsc_result_t)-1:0]    m_tdata,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [2:0]                         cfg_addr,
    input  logic [15:0]                        cfg_wdata
);

    localparam int unsigned RomDepth = 2 ** ADC_BITS;

    // Configuration registers.
    logic [15:0] sample_period_reg;
    logic [15:0] min_distance_reg;
    logic [15:0] max_distance_reg;
    logic [15:0] max_jump_reg;
    logic [15:0] ema_alpha_reg;
    logic [15:0] fresh_limit_reg;

    // Handshake between stages.
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    logic en1, en2, en3;

    // Stage 1: input time and table output.
    logic [31:0] now1_reg;
    logic [15:0] raw1_reg;

    // Stage 2 state and word.
    logic [31:0] last_read_time_reg;
    logic [31:0] last_sample_time_reg;
    logic        have_sample_reg;
    logic [15:0] last_distance_reg;
    logic [15:0] valid_count_reg;
    logic [15:0] timeout_count_reg;
    logic        timeout_seen_reg;
    irsc_cond_t  cond_reg;
    irsc_cond_t  cond_next;
    logic [15:0] cm2_reg;
    logic [15:0] cm_next;

    // Stage 2 combinational terms.
    logic [31:0] since_read;
    logic        take;
    logic        good;
    logic [16:0] jump_up;
    logic        have_next;
    logic [15:0] valid_count_next;
    logic [15:0] timeout_count_next;
    logic        timeout_seen_next;
    logic [15:0] last_distance_next;

    // Stage 3 state and averaging terms.
    logic               average_seeded_reg;
    logic [23:0]        average_reg;
    logic [23:0]        average_next;
    logic signed [24:0] ema_diff;
    logic signed [41:0] ema_prod;
    logic signed [41:0] ema_sum;
    logic [24:0]        filt_sum;
    irsc_result_t       result_reg;
    irsc_result_t       result_next;

    // Conversion table, built at elaboration.
    logic [15:0] rom_tbl [RomDepth];

    for (genvar gi = 0; gi < RomDepth; gi++) begin : g_rom
        localparam logic [15:0] Entry = irsc_adc_to_dist(gi, ADC_BITS, DIST_FRAC_BITS);
        assign rom_tbl[gi] = Entry;
    end

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_period_reg <= RST_SAMPLE_PERIOD;
            min_distance_reg  <= RST_MIN_DISTANCE;
            max_distance_reg  <= RST_MAX_DISTANCE;
            max_jump_reg      <= RST_MAX_JUMP;
            ema_alpha_reg     <= RST_EMA_ALPHA;
            fresh_limit_reg   <= RST_FRESH_LIMIT;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_SAMPLE_PERIOD: sample_period_reg <= cfg_wdata;
                CFG_MIN_DISTANCE:  min_distance_reg  <= cfg_wdata;
                CFG_MAX_DISTANCE:  max_distance_reg  <= cfg_wdata;
                CFG_MAX_JUMP:      max_jump_reg      <= cfg_wdata;
                CFG_EMA_ALPHA:     ema_alpha_reg     <= cfg_wdata;
                CFG_FRESH_LIMIT:   fresh_limit_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A stage takes a new word when it is empty or its word moves on.
    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign en1      = s_tvalid && rdy1;
    assign en2      = v1_reg && rdy2;
    assign en3      = v2_reg && rdy3;
    assign s_tready = rdy1;
    assign m_tvalid = v3_reg;
    assign m_tdata  = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // Stage 1: capture the time and read the conversion table.
    always_ff @(posedge aclk) begin
        if (en1) begin
            now1_reg <= s_tdata[31:0];
            raw1_reg <= rom_tbl[s_tdata[32 +: ADC_BITS]];
        end
    end

    // Stage 2: read gating, range check, jump limit and counters.
    always_comb begin
        since_read = now1_reg - last_read_time_reg;
        take       = since_read >= {16'd0, sample_period_reg};
        good       = take && raw1_reg >= min_distance_reg && raw1_reg <= max_distance_reg;
        jump_up    = {1'b0, last_distance_reg} + {1'b0, max_jump_reg};

        // Limit the new distance to the last one plus or minus the jump.
        cm_next = raw1_reg;
        if (have_sample_reg) begin
            if (raw1_reg > last_distance_reg
                    && raw1_reg - last_distance_reg > max_jump_reg) begin
                cm_next = jump_up[16] ? DIST_MAX : jump_up[15:0];
            end else if (raw1_reg < last_distance_reg
                    && last_distance_reg - raw1_reg > max_jump_reg) begin
                cm_next = last_distance_reg - max_jump_reg;
            end
        end

        have_next          = have_sample_reg || good;
        last_distance_next = good ? cm_next : last_distance_reg;
        valid_count_next   = valid_count_reg;
        timeout_count_next = timeout_count_reg;
        timeout_seen_next  = timeout_seen_reg;
        if (good) begin
            timeout_seen_next = 1'b0;
            if (valid_count_reg != DIST_MAX) valid_count_next = valid_count_reg + 16'd1;
        end else if (take) begin
            timeout_seen_next = 1'b1;
            if (timeout_count_reg != DIST_MAX) timeout_count_next = timeout_count_reg + 16'd1;
        end

        cond_next.accepted       = take;
        cond_next.in_range       = good;
        cond_next.sample_present = have_next;
        cond_next.timeout        = timeout_seen_next;
        cond_next.distance       = last_distance_next;
        cond_next.streak         = valid_count_next;
        cond_next.timeouts       = timeout_count_next;
        if (!have_next) begin
            cond_next.age_ms = AGE_NONE;
        end else if (good) begin
            cond_next.age_ms = 32'd0;
        end else begin
            cond_next.age_ms = now1_reg - last_sample_time_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_read_time_reg   <= 32'd0;
            last_sample_time_reg <= 32'd0;
            have_sample_reg      <= 1'b0;
            last_distance_reg    <= 16'd0;
            valid_count_reg      <= 16'd0;
            timeout_count_reg    <= 16'd0;
            timeout_seen_reg     <= 1'b0;
        end else if (en2) begin
            if (take) last_read_time_reg <= now1_reg;
            if (good) last_sample_time_reg <= now1_reg;
            have_sample_reg   <= have_next;
            last_distance_reg <= last_distance_next;
            valid_count_reg   <= valid_count_next;
            timeout_count_reg <= timeout_count_next;
            timeout_seen_reg  <= timeout_seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            cond_reg <= cond_next;
            cm2_reg  <= cm_next;
        end
    end

    // Stage 3: exponential average as avg + alpha * (new - avg), rounded.
    always_comb begin
        ema_diff = $signed({1'b0, cm2_reg, 8'd0}) - $signed({1'b0, average_reg});
        ema_prod = $signed({1'b0, ema_alpha_reg}) * ema_diff;
        ema_sum  = $signed({2'b00, average_reg, 16'd0}) + ema_prod + 42'sd32768;

        average_next = average_reg;
        if (cond_reg.in_range) begin
            average_next = average_seeded_reg ? ema_sum[39:16] : {cm2_reg, 8'd0};
        end

        filt_sum = {1'b0, average_next} + 25'd128;

        result_next.pad            = 3'd0;
        result_next.accepted       = cond_reg.accepted;
        result_next.in_range       = cond_reg.in_range;
        result_next.sample_present = cond_reg.sample_present;
        result_next.timeout        = cond_reg.timeout;
        result_next.distance       = cond_reg.distance;
        result_next.filtered       = filt_sum[24] ? DIST_MAX : filt_sum[23:8];
        result_next.age_ms         = cond_reg.age_ms;
        result_next.fresh          = cond_reg.sample_present
                                     && cond_reg.age_ms <= {16'd0, fresh_limit_reg};
        result_next.streak         = cond_reg.streak;
        result_next.timeouts       = cond_reg.timeouts;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            average_seeded_reg <= 1'b0;
            average_reg        <= 24'd0;
        end else if (en3) begin
            if (cond_reg.in_range) average_seeded_reg <= 1'b1;
            average_reg <= average_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) result_reg <= result_next;
    end

endmodule

[tb/ir_range_sample_conditioner_unit_test.sv]
module ir_range_sample_conditioner_unit_test
    import irsc_pkg::*;
();

    localparam int CODE_BITS = 10;
    localparam int FRAC_BITS = 8;

    // Expected-result bookkeeping: mirrors the conditioner state and holds the words
    // still to come out of the block.
    class range_scoreboard;
        logic [15:0]  dist_rom [1024];
        logic [15:0]  period_ms, min_dist, max_dist, jump_lim, alpha, fresh_lim_ms;
        logic [31:0]  last_read_ms, last_good_ms;
        logic         have_good, avg_seeded, timed_out;
        logic [15:0]  last_dist, good_count, bad_count;
        logic [23:0]  avg_q16;
        irsc_result_t expected_q[$];
        int           errors;

        // Build the code-to-distance table and start from the reset state.
        function new();
            logic [63:0] u, e, p, root, v, r, cand, prod, lg5;
            int          ip, s;
            lg5 = log2_q16(32'd5);
            for (int code = 0; code < (1 << CODE_BITS); code++) begin
                dist_rom[code] = 16'd0;
                if (code < 10 || code * 100 < (1 << CODE_BITS)) continue;
                // Exponent of the power law in Q16, biased by eight.
                u = 64'd76874 * ((64'(CODE_BITS) << 16) - lg5) + (64'd8 << 32)
                    - 64'd76874 * log2_q16(32'(code));
                e = u >> 16;
                ip = int'(e >> 16);
                // Fractional power of two in Q30 from repeated square roots of two.
                p = 64'd1 << 30;
                root = 64'd2 << 30;
                for (int k = 0; k < 16; k++) begin
                    v = root << 30;
                    r = 64'd0;
                    for (int b = 31; b >= 0; b--) begin
                        cand = r | (64'd1 << b);
                        if (cand * cand <= v) r = cand;
                    end
                    root = r;
                    if (e[15-k]) p = (p * root) >> 30;
                end
                s = 54 - ip - FRAC_BITS;
                if (s < 1) begin
                    dist_rom[code] = DIST_MAX;
                end else if (s <= 62) begin
                    prod = (64'd1965294 * p + (64'd1 << (s - 1))) >> s;
                    dist_rom[code] = (prod > 64'hFFFF) ? DIST_MAX : prod[15:0];
                end
            end
            period_ms = RST_SAMPLE_PERIOD;
            min_dist = RST_MIN_DISTANCE;
            max_dist = RST_MAX_DISTANCE;
            jump_lim = RST_MAX_JUMP;
            alpha = RST_EMA_ALPHA;
            fresh_lim_ms = RST_FRESH_LIMIT;
            last_read_ms = '0;
            last_good_ms = '0;
            have_good = 1'b0;
            avg_seeded = 1'b0;
            timed_out = 1'b0;
            last_dist = '0;
            good_count = '0;
            bad_count = '0;
            avg_q16 = '0;
            errors = 0;
        endfunction

        // Truncated base-two logarithm in Q16, fraction found by repeated squaring.
        function logic [63:0] log2_q16(logic [31:0] x);
            logic [63:0] m, frac;
            int          n;
            n = 0;
            for (int i = 0; i < 32; i++) begin
                if (x[i]) n = i;
            end
            m = (64'(x) << 16) >> n;
            frac = '0;
            repeat (16) begin
                m = (m * m) >> 16;
                frac = {frac[62:0], 1'b0};
                if (m >= 64'h2_0000) begin
                    m = m >> 1;
                    frac[0] = 1'b1;
                end
            end
            return (64'(n) << 16) | frac;
        endfunction

        function void set_register(logic [2:0] idx, logic [15:0] val);
            case (idx)
                CFG_SAMPLE_PERIOD: period_ms = val;
                CFG_MIN_DISTANCE:  min_dist = val;
                CFG_MAX_DISTANCE:  max_dist = val;
                CFG_MAX_JUMP:      jump_lim = val;
                CFG_EMA_ALPHA:     alpha = val;
                CFG_FRESH_LIMIT:   fresh_lim_ms = val;
                default: ;
            endcase
        endfunction

        // Advance the mirrored state by one accepted input word and queue its result.
        function void note_input(logic [31:0] now, logic [CODE_BITS-1:0] code);
            irsc_result_t r;
            logic [31:0]  since_read, age;
            logic [15:0]  raw;
            logic [16:0]  cm;
            logic [63:0]  mix;
            logic [24:0]  rounded;
            r = '0;
            since_read = now - last_read_ms;
            if (since_read >= 32'(period_ms)) begin
                raw = dist_rom[code];
                r.accepted = 1'b1;
                last_read_ms = now;
                if (raw >= min_dist && raw <= max_dist) begin
                    r.in_range = 1'b1;
                    cm = {1'b0, raw};
                    // Limit the step away from the previous good distance.
                    if (have_good) begin
                        if (raw > last_dist && raw - last_dist > jump_lim) begin
                            cm = {1'b0, last_dist} + {1'b0, jump_lim};
                            if (cm > 17'h0FFFF) cm = 17'h0FFFF;
                        end else if (raw < last_dist && last_dist - raw > jump_lim) begin
                            cm = {1'b0, last_dist - jump_lim};
                        end
                    end
                    if (!avg_seeded) begin
                        avg_q16 = {cm[15:0], 8'd0};
                        avg_seeded = 1'b1;
                    end else begin
                        mix = (64'(alpha) * (64'(cm[15:0]) << 8)
                            + (64'd65536 - 64'(alpha)) * 64'(avg_q16) + 64'd32768) >> 16;
                        avg_q16 = mix[23:0];
                    end
                    last_dist = cm[15:0];
                    last_good_ms = now;
                    have_good = 1'b1;
                    timed_out = 1'b0;
                    if (good_count != 16'hFFFF) good_count++;
                end else begin
                    timed_out = 1'b1;
                    if (bad_count != 16'hFFFF) bad_count++;
                end
            end
            age = have_good ? now - last_good_ms : AGE_NONE;
            rounded = {1'b0, avg_q16} + 25'd128;
            r.filtered = (rounded[24:8] > 17'h0FFFF) ? DIST_MAX : rounded[23:8];
            r.sample_present = have_good;
            r.timeout = timed_out;
            r.distance = last_dist;
            r.age_ms = age;
            r.fresh = have_good && (age <= 32'(fresh_lim_ms));
            r.streak = good_count;
            r.timeouts = bad_count;
            expected_q.push_back(r);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(irsc_result_t got);
            irsc_result_t want;
            if (expected_q.size() == 0) begin
                $error("result word with no pending expectation");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare("accepted", want.accepted, got.accepted);
            compare("in_range", want.in_range, got.in_range);
            compare("sample_present", want.sample_present, got.sample_present);
            compare("timeout", want.timeout, got.timeout);
            compare("distance", want.distance, got.distance);
            compare("filtered", want.filtered, got.filtered);
            compare("age_ms", want.age_ms, got.age_ms);
            compare("fresh", want.fresh, got.fresh);
            compare("streak", want.streak, got.streak);
            compare("timeouts", want.timeouts, got.timeouts);
        endfunction
    endclass

    logic                              aclk;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    // now_ms, adc_sample, zero fill.
    logic [47:0]                       s_tdata;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    // accepted, in_range, sample_present, timeout, distance, filtered, age_ms, fresh,
    // streak, timeouts, zero fill.
    logic [$bits(irsc_result_t)-1:0]   m_tdata;
    logic                              cfg_we;
    logic [2:0]                        cfg_addr;
    logic [15:0]                       cfg_wdata;

    range_scoreboard sb;
    int              burst_left = 0;
    int              rx_mode = 0;
    int              rx_left = 0;
    int              rx_cyc = 0;
    logic [31:0]     clock_ms;

    ir_range_sample_conditioner_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit.
    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    // Receiver back-pressure: modes from always ready to periodic and random stalls.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_cyc <= rx_cyc + 1;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_cyc % 5) != 0;
            default: m_tready <= (rx_cyc % 11) >= 4;
        endcase
    end

    // Check every result word taken by the receiver.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(irsc_result_t'(m_tdata));
    end

    // Present one word, with a random gap when a new burst starts. Called at a falling edge.
    task automatic send_word(input logic [31:0] now, input logic [CODE_BITS-1:0] code);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, code, now};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(now, code);
        @(negedge aclk);
        burst_left--;
    endtask

    // Drop valid and wait until every expected word has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        sb.set_register(idx, val);
        @(negedge aclk);
    endtask

    task automatic configure(input logic [15:0] period, input logic [15:0] lo,
                             input logic [15:0] hi, input logic [15:0] jump,
                             input logic [15:0] weight, input logic [15:0] fresh_ms);
        write_reg(CFG_SAMPLE_PERIOD, period);
        write_reg(CFG_MIN_DISTANCE, lo);
        write_reg(CFG_MAX_DISTANCE, hi);
        write_reg(CFG_MAX_JUMP, jump);
        write_reg(CFG_EMA_ALPHA, weight);
        write_reg(CFG_FRESH_LIMIT, fresh_ms);
        cfg_we <= 1'b0;
    endtask

    // One random phase: pick a setting, then stream timestamps and codes.
    task automatic run_random_phase(input int count);
        logic [15:0]          period, lo, hi, jump, weight, fresh_ms;
        logic [31:0]          step;
        logic [CODE_BITS-1:0] code;
        case ($urandom_range(0, 4))
            0: period = 16'd0;
            1: period = 16'hFFFF;
            2: period = RST_SAMPLE_PERIOD;
            default: period = 16'($urandom_range(1, 100));
        endcase
        case ($urandom_range(0, 3))
            0: begin
                lo = RST_MIN_DISTANCE;
                hi = RST_MAX_DISTANCE;
            end
            1: begin
                lo = 16'd0;
                hi = 16'hFFFF;
            end
            2: begin
                lo = 16'($urandom_range(0, 8000));
                hi = lo + 16'($urandom_range(0, 30000));
            end
            default: begin
                lo = 16'($urandom);
                hi = 16'($urandom);
            end
        endcase
        case ($urandom_range(0, 3))
            0: jump = 16'd0;
            1: jump = 16'hFFFF;
            2: jump = 16'($urandom_range(0, 8000));
            default: jump = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: weight = 16'd0;
            1: weight = 16'hFFFF;
            default: weight = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: fresh_ms = 16'd0;
            1: fresh_ms = 16'hFFFF;
            default: fresh_ms = 16'($urandom_range(0, 200));
        endcase
        drain();
        configure(period, lo, hi, jump, weight, fresh_ms);
        repeat (count) begin
            // Mostly steps at or just past the sample period, some early, some far off.
            case ($urandom_range(0, 9))
                0: step = $urandom;
                1: step = 32'd0;
                2, 3: step = $urandom_range(0, period);
                default: step = 32'(period) + $urandom_range(0, 30);
            endcase
            clock_ms = clock_ms + step;
            // Mostly codes inside the usual range window, with both ends visited.
            case ($urandom_range(0, 7))
                0: code = CODE_BITS'($urandom_range(0, 1023));
                1: code = CODE_BITS'($urandom_range(0, 12));
                2: code = CODE_BITS'($urandom_range(900, 1023));
                default: code = CODE_BITS'($urandom_range(100, 700));
            endcase
            send_word(clock_ms, code);
        end
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = CFG_SAMPLE_PERIOD;
        cfg_wdata = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: period gating, empty history, codes that map to zero or
        // saturate, jump limiting both ways, the freshness edge and the time wrap.
        send_word(32'd0, 10'd300);
        send_word(32'd39, 10'd300);
        send_word(32'd40, 10'd300);
        send_word(32'd50, 10'd300);
        send_word(32'd80, 10'd0);
        send_word(32'd120, 10'd9);
        send_word(32'd160, 10'd10);
        send_word(32'd200, 10'd11);
        send_word(32'd240, 10'd1023);
        send_word(32'd280, 10'd110);
        send_word(32'd320, 10'd450);
        send_word(32'd420, 10'd0);
        send_word(32'd421, 10'd0);
        send_word(32'hFFFF_FFF0, 10'd300);
        send_word(32'h0000_0020, 10'd300);
        drain();

        // Low extremes: every read taken, whole range valid, no movement allowed.
        configure(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        send_word(32'h0000_0020, 10'd0);
        send_word(32'h0000_0020, 10'd11);
        send_word(32'h0000_0021, 10'd1023);
        send_word(32'h0000_0021, 10'd512);
        drain();

        // High extremes: only full-scale distances valid, longest period.
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(32'h0000_0021 + 32'd65535, 10'd11);
        send_word(32'h0000_0021 + 32'd131069, 10'd300);
        send_word(32'h0000_0021 + 32'd131070, 10'd1023);

        clock_ms = $urandom;
        repeat (7) run_random_phase(250);
        drain();
        repeat (10) @(negedge aclk);

        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[ir_range_sample_conditioner_unit.f]
rtl/core/irsc_pkg.sv
rtl/core/ir_range_sample_conditioner_unit.sv
tb/ir_range_sample_conditioner_unit_test.sv
